FILE: sv/ciw_pkg.sv
// Shared types, constants and ready-rule functions for the collapsing issue window.
// No dependencies; imported by ciw_cell and collapsing_issue_window.
`default_nettype none

package ciw_pkg;

  localparam int WINDOW_DEPTH = 6;
  localparam int NUM_REGS     = 32;
  localparam int WB_SLOTS     = 16;
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int SLOT_W       = $clog2(WB_SLOTS);

  localparam logic [2:0] STORE_OPCODE = 3'd3;
  localparam logic [2:0] FLOAT_OPCODE = 3'd5;
  localparam logic       OP_INSERT    = 1'b0;
  localparam logic       OP_ISSUE     = 1'b1;

  typedef struct packed {
    logic        op;
    logic [2:0]  opcode;
    logic [4:0]  src_one;
    logic [4:0]  src_two;
    logic [4:0]  dest_reg;
    logic [15:0] payload_tag;
    logic [31:0] reg_ready;
    logic [15:0] wb_busy;
    logic        float_free;
  } ciw_req_t;

  typedef struct packed {
    logic        issued;
    logic [2:0]  out_opcode;
    logic [4:0]  out_src_one;
    logic [4:0]  out_src_two;
    logic [4:0]  out_dest;
    logic [15:0] out_tag;
    logic [2:0]  occupancy;
    logic        has_room;
    logic        overflow;
  } ciw_rsp_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [4:0]  src_one;
    logic [4:0]  src_two;
    logic [4:0]  dest;
    logic [15:0] tag;
  } ciw_entry_t;

  typedef struct packed {
    logic        insert;
    logic        issue;
    logic [31:0] reg_ready;
    logic [15:0] wb_busy;
    logic        float_free;
    logic [31:0] latency_table;
  } ciw_ctl_t;

  function automatic logic src_ok(input logic [4:0] r, input logic [31:0] mask);
    src_ok = (r == 5'd0) || ((32'(r) < 32'(NUM_REGS)) && mask[r]);
  endfunction

  function automatic logic entry_ok(input ciw_entry_t e, input ciw_ctl_t c);
    logic       is_store;
    logic [4:0] slot;
    logic       wb_ok;
    is_store = (e.opcode == STORE_OPCODE);
    slot     = {1'b0, c.latency_table[{e.opcode, 2'b00} +: 4]} + 5'd2;
    wb_ok    = is_store || (e.dest == 5'd0) || (32'(slot) >= 32'(WB_SLOTS)) ||
               !c.wb_busy[slot[SLOT_W-1:0]];
    entry_ok = src_ok(e.src_one, c.reg_ready) && src_ok(e.src_two, c.reg_ready) &&
               (!is_store || src_ok(e.dest, c.reg_ready)) && wb_ok &&
               ((e.opcode != FLOAT_OPCODE) || c.float_free);
  endfunction

endpackage

`default_nettype wire

FILE: sv/ciw_cell.sv
// One window slot: holds an entry, checks readiness, passes the oldest-first
// select chain on, and takes its younger neighbor's entry on compaction. Uses ciw_pkg.
`default_nettype none

module ciw_cell import ciw_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire ciw_ctl_t   ctl,
  input  wire ciw_entry_t new_entry,
  input  wire logic       prev_valid,
  input  wire logic       take_before,
  input  wire ciw_entry_t next_entry,
  input  wire logic       next_valid,
  output ciw_entry_t      entry,
  output logic            valid,
  output logic            sel,
  output logic            take_after
);

  logic shift;
  logic fill;

  assign sel        = valid && !take_before && entry_ok(entry, ctl);
  assign take_after = take_before || sel;
  assign shift      = ctl.issue && take_after;
  assign fill       = ctl.insert && !valid && prev_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= next_valid;
    end else if (fill) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      entry <= next_entry;
    end else if (fill) begin
      entry <= new_entry;
    end
  end

endmodule

`default_nettype wire

FILE: sv/collapsing_issue_window.sv
// Collapsing issue window with oldest-first select: top level.
// Depends on ciw_pkg and a row of ciw_cell slots.
//
// Request channel req_valid/req_stall carries a ciw_req_t item: op OP_INSERT
// appends an instruction, op OP_ISSUE selects the oldest ready entry. The
// response channel rsp_valid/rsp_stall returns one ciw_rsp_t item per request.
// Each slot tests its own entry against the request's ready mask, busy mask
// and float flag; a priority chain through the slots picks the oldest, and
// every slot at or above the pick takes its neighbor's entry to close the gap.
// rsp_valid is set in the cycle after acceptance. One item is accepted per
// cycle while req_stall is low; the limit is the select chain through the
// six slots, which settles within the accept cycle. The response register
// holds its item while rsp_stall is high, and req_stall is raised while a
// held item waits. cfg_write loads the latency table (nibble n is the
// writeback latency of opcode n); the user must use it only while the
// window is idle, and the block itself does not enforce this. Reset empties
// the window, clears the latency table and drops any pending response.
`default_nettype none

module collapsing_issue_window import ciw_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire ciw_req_t    req,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output ciw_rsp_t         rsp,
  input  wire logic        cfg_write,
  input  wire logic [31:0] cfg_data
);

  logic [31:0]             latency_table;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic                    accept;
  ciw_ctl_t                ctl;
  ciw_entry_t              new_entry;
  ciw_entry_t              cell_entry [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] cell_valid;
  logic [WINDOW_DEPTH-1:0] cell_sel;
  logic [WINDOW_DEPTH:0]   take;
  ciw_entry_t              sel_entry;
  logic                    any_sel;
  logic                    full;
  ciw_rsp_t                rsp_next;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;
  assign full      = (count == CNT_W'(WINDOW_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      latency_table <= '0;
    end else if (cfg_write) begin
      latency_table <= cfg_data;
    end
  end

  always_comb begin
    ctl.insert        = accept && (req.op == OP_INSERT);
    ctl.issue         = accept && (req.op == OP_ISSUE);
    ctl.reg_ready     = req.reg_ready;
    ctl.wb_busy       = req.wb_busy;
    ctl.float_free    = req.float_free;
    ctl.latency_table = latency_table;
    new_entry.opcode  = req.opcode;
    new_entry.src_one = req.src_one;
    new_entry.src_two = req.src_two;
    new_entry.dest    = req.dest_reg;
    new_entry.tag     = req.payload_tag;
  end

  assign take[0] = 1'b0;

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    logic       prev_v;
    logic       next_v;
    ciw_entry_t next_e;
    if (i == 0) begin : g_first
      assign prev_v = 1'b1;
    end else begin : g_rest
      assign prev_v = cell_valid[i-1];
    end
    if (i == WINDOW_DEPTH - 1) begin : g_last
      assign next_v = 1'b0;
      assign next_e = cell_entry[i];
    end else begin : g_inner
      assign next_v = cell_valid[i+1];
      assign next_e = cell_entry[i+1];
    end
    ciw_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .new_entry   (new_entry),
      .prev_valid  (prev_v),
      .take_before (take[i]),
      .next_entry  (next_e),
      .next_valid  (next_v),
      .entry       (cell_entry[i]),
      .valid       (cell_valid[i]),
      .sel         (cell_sel[i]),
      .take_after  (take[i+1])
    );
  end

  assign any_sel = take[WINDOW_DEPTH];

  always_comb begin
    sel_entry = '0;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      sel_entry = ciw_entry_t'(sel_entry |
                               (cell_entry[i] & {$bits(ciw_entry_t){cell_sel[i]}}));
    end
  end

  always_comb begin
    priority if (ctl.insert && !full) begin
      count_next = count + CNT_W'(1);
    end else if (ctl.issue && any_sel) begin
      count_next = count - CNT_W'(1);
    end else begin
      count_next = count;
    end
  end

  always_comb begin
    rsp_next             = '0;
    if (req.op == OP_ISSUE && any_sel) begin
      rsp_next.issued      = 1'b1;
      rsp_next.out_opcode  = sel_entry.opcode;
      rsp_next.out_src_one = sel_entry.src_one;
      rsp_next.out_src_two = sel_entry.src_two;
      rsp_next.out_dest    = sel_entry.dest;
      rsp_next.out_tag     = sel_entry.tag;
    end
    rsp_next.occupancy   = 3'(count_next);
    rsp_next.has_room    = (count_next < CNT_W'(WINDOW_DEPTH));
    rsp_next.overflow    = (req.op == OP_INSERT) && full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    32'($countones(cell_valid)) == 32'(count))
    else $error("window count disagrees with occupied slots");

  a_no_holes: assert property (@(posedge clk) disable iff (rst)
    ((cell_valid >> 1) & ~cell_valid) == '0)
    else $error("hole in the window");

  a_single_pick: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cell_sel))
    else $error("more than one slot selected");

  a_issue_shrinks: assert property (@(posedge clk) disable iff (rst)
    ctl.issue && any_sel |=> count == $past(count) - CNT_W'(1))
    else $error("issue did not remove an entry");

endmodule

`default_nettype wire
